FILE: rtl/cdtl_pkg.sv
// shared types, widths and constants for the cubemap direction texel lookup
`default_nettype none

package cdtl_pkg;

    // fixed design limits
    localparam int MAX_FACE_SIZE     = 2048;
    localparam int DIR_FRACTION_BITS = 14;

    // smallest major-axis magnitude, ceil(0.0001 * 2^frac) at least one lsb
    localparam int FLOOR_RAW = ((1 << DIR_FRACTION_BITS) + 9999) / 10000;
    localparam int FLOOR_MAG = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;

    // field and datapath widths
    localparam int DIR_W  = 16;               // direction component
    localparam int CRD_W  = DIR_W + 1;        // signed face coordinate
    localparam int MAG_W  = DIR_W;            // magnitude, holds 2^15
    localparam int NRM_W  = MAG_W + 1;        // shifted coordinate and 2*m
    localparam int TEX_W  = 11;               // texel coordinate
    localparam int SIZE_W = 12;               // face size register
    localparam int NUM_W  = NRM_W + TEX_W;    // dividend n*span
    localparam int SQ_W   = 2 * TEX_W + 1;    // size squared
    localparam int PROD_W = TEX_W + SIZE_W;   // row times size
    localparam int IDX_W  = 25;               // linear texel index
    localparam int FACE_W = 3;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // result of face selection, first pipeline stage
    typedef struct packed {
        t_face            face;
        logic [CRD_W-1:0] u;
        logic [CRD_W-1:0] v;
        logic [MAG_W-1:0] mag;
    } t_face_sel;

endpackage

`default_nettype wire

FILE: rtl/cdtl_face_sel.sv
// face selection by major axis and face coordinate sign table, one register stage
`default_nettype none

module cdtl_face_sel
    import cdtl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DIR_W-1:0] i_dir_x,
    input  wire logic [DIR_W-1:0] i_dir_y,
    input  wire logic [DIR_W-1:0] i_dir_z,
    output t_face_sel             o_sel
);

    t_face_sel             r_sel;
    t_face_sel             n_sel;
    logic signed [CRD_W-1:0] xs, ys, zs, nx, ny, nz;
    logic [MAG_W-1:0]      ax, ay, az;
    logic                  x_pos, y_pos, z_pos;

    always_comb begin
        xs = {i_dir_x[DIR_W-1], i_dir_x};
        ys = {i_dir_y[DIR_W-1], i_dir_y};
        zs = {i_dir_z[DIR_W-1], i_dir_z};
        nx = -xs;
        ny = -ys;
        nz = -zs;
        ax = xs[CRD_W-1] ? nx[MAG_W-1:0] : xs[MAG_W-1:0];
        ay = ys[CRD_W-1] ? ny[MAG_W-1:0] : ys[MAG_W-1:0];
        az = zs[CRD_W-1] ? nz[MAG_W-1:0] : zs[MAG_W-1:0];
        x_pos = !i_dir_x[DIR_W-1] && (i_dir_x != '0);
        y_pos = !i_dir_y[DIR_W-1] && (i_dir_y != '0);
        z_pos = !i_dir_z[DIR_W-1] && (i_dir_z != '0);

        // z wins ties, then x over y
        if (az >= ax && az >= ay) begin
            n_sel.face = z_pos ? FACE_POS_Z : FACE_NEG_Z;
            n_sel.u    = z_pos ? xs : nx;
            n_sel.v    = ys;
            n_sel.mag  = az;
        end else if (ax >= ay) begin
            n_sel.face = x_pos ? FACE_POS_X : FACE_NEG_X;
            n_sel.u    = x_pos ? nz : zs;
            n_sel.v    = ys;
            n_sel.mag  = ax;
        end else begin
            n_sel.face = y_pos ? FACE_POS_Y : FACE_NEG_Y;
            n_sel.u    = xs;
            n_sel.v    = y_pos ? nz : zs;
            n_sel.mag  = ay;
        end

        if (n_sel.mag < MAG_W'(FLOOR_MAG)) begin
            n_sel.mag = MAG_W'(FLOOR_MAG);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
        end
    end

    assign o_sel = r_sel;

endmodule

`default_nettype wire

FILE: rtl/cdtl_scale.sv
// shift coordinate into [0, 2m] and scale by size minus one, two register stages
`default_nettype none

module cdtl_scale
    import cdtl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [CRD_W-1:0] i_coord,
    input  wire logic [MAG_W-1:0] i_mag,
    input  wire logic [TEX_W-1:0] i_span,
    output logic      [NUM_W-1:0] o_num,
    output logic      [NRM_W-1:0] o_den
);

    logic signed [CRD_W:0] sum;
    logic [NRM_W-1:0]      den2;
    logic [NRM_W-1:0]      n_n;
    logic [NRM_W-1:0]      r_n;
    logic [NRM_W-1:0]      r_den2;
    logic [NUM_W-1:0]      r_num;
    logic [NRM_W-1:0]      r_den;

    always_comb begin
        sum  = $signed({i_coord[CRD_W-1], i_coord}) + $signed({2'b00, i_mag});
        den2 = {i_mag, 1'b0};
        if (sum[CRD_W]) begin
            n_n = '0;
        end else if (sum[NRM_W-1:0] > den2) begin
            n_n = den2;
        end else begin
            n_n = sum[NRM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= n_n;
            r_den2 <= den2;
            r_num  <= NUM_W'(r_n) * NUM_W'(i_span);
            r_den  <= r_den2;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

`default_nettype wire

FILE: rtl/cdtl_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module cdtl_div
    import cdtl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [NRM_W-1:0] i_den,
    output logic      [TEX_W-1:0] o_quot
);

    // quotient never exceeds size minus one, so the top bits start as remainder
    logic [NRM_W-1:0] r_rem  [TEX_W];
    logic [NUM_W-1:0] r_num  [TEX_W];
    logic [NRM_W-1:0] r_den  [TEX_W];
    logic [TEX_W-1:0] r_quot [TEX_W];
    logic [NRM_W-1:0] n_rem  [TEX_W];
    logic [TEX_W-1:0] n_quot [TEX_W];

    always_comb begin
        logic [NRM_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NRM_W-1:0] den_in;
        logic [TEX_W-1:0] quot_in;
        logic [NRM_W:0]   trial;
        for (int k = 0; k < TEX_W; k++) begin
            if (k == 0) begin
                num_in  = i_num;
                den_in  = i_den;
                rem_in  = i_num[NUM_W-1:TEX_W];
                quot_in = '0;
            end else begin
                num_in  = r_num[k-1];
                den_in  = r_den[k-1];
                rem_in  = r_rem[k-1];
                quot_in = r_quot[k-1];
            end
            trial = {rem_in, num_in[TEX_W-1-k]};
            if (trial >= {1'b0, den_in}) begin
                n_rem[k]  = NRM_W'(trial - {1'b0, den_in});
                n_quot[k] = {quot_in[TEX_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = trial[NRM_W-1:0];
                n_quot[k] = {quot_in[TEX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < TEX_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_quot[k] <= n_quot[k];
            end
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            for (int k = 1; k < TEX_W; k++) begin
                r_num[k] <= r_num[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quot = r_quot[TEX_W-1];

endmodule

`default_nettype wire

FILE: rtl/cdtl_addr.sv
// linear texel index, two register stages
`default_nettype none

module cdtl_addr
    import cdtl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire t_face             i_face,
    input  wire logic [IDX_W-1:0]  i_face_off,
    input  wire logic [TEX_W-1:0]  i_tx,
    input  wire logic [TEX_W-1:0]  i_ty,
    input  wire logic [SIZE_W-1:0] i_size,
    output t_face                  o_face,
    output logic      [TEX_W-1:0]  o_tx,
    output logic      [TEX_W-1:0]  o_ty,
    output logic      [IDX_W-1:0]  o_idx
);

    t_face             r_face_a, r_face_b;
    logic [TEX_W-1:0]  r_tx_a, r_tx_b, r_ty_a, r_ty_b;
    logic [PROD_W-1:0] r_prod;
    logic [IDX_W-1:0]  r_base;
    logic [IDX_W-1:0]  r_idx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // row times size, and face offset plus column
            r_prod   <= PROD_W'(i_ty) * PROD_W'(i_size);
            r_base   <= i_face_off + IDX_W'(i_tx);
            r_face_a <= i_face;
            r_tx_a   <= i_tx;
            r_ty_a   <= i_ty;

            r_idx    <= r_base + IDX_W'(r_prod);
            r_face_b <= r_face_a;
            r_tx_b   <= r_tx_a;
            r_ty_b   <= r_ty_a;
        end
    end

    assign o_face = r_face_b;
    assign o_tx   = r_tx_b;
    assign o_ty   = r_ty_b;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

FILE: rtl/cubemap_direction_texel_lookup_top.sv
// top level of the cubemap direction to face and nearest texel lookup
//
// channel   dir   handshake                    payload
// s_axis    in    s_axis_tvalid/tready         tdata: dir_x, dir_y, dir_z
// m_axis    out   m_axis_tvalid/tready         tdata: face, texel_x, texel_y, texel_index
// cfg       in    i_cfg_valid/o_cfg_ready      i_cfg_data: face_size
//
// one item per cycle sustained while the output register is empty or taken
// the divider has 11 stages, one quotient bit per stage
// reset clears all stage valid bits and loads face_size with 128
// the whole pipeline advances when the output register is empty or taken;
// otherwise every stage holds and s_axis_tready is low
// config writes are always accepted and must be made while the pipe is empty
`default_nettype none

module cubemap_direction_texel_lookup_top
    import cdtl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // item in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // item out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // face [2:0], texel_x [13:3], texel_y [24:14], texel_index [49:25], zero [55:50]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,

    // face_size register write
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [SIZE_W-1:0]      i_cfg_data
);

    // stages: select 1, scale 2, divide 11, address 2
    localparam int PIPE_DEPTH = 3 + TEX_W + 2;

    logic                r_vld [PIPE_DEPTH];
    logic                en;

    logic [SIZE_W-1:0]   r_face_size;
    logic [SIZE_W-1:0]   size;
    logic [TEX_W-1:0]    span;
    logic [SQ_W-1:0]     r_size_sq;

    t_face_sel           sel;
    t_face               r_face_s2, r_face_s3;
    logic [IDX_W-1:0]    r_off_s2, r_off_s3;
    t_face               r_face_d [TEX_W];
    logic [IDX_W-1:0]    r_off_d  [TEX_W];

    logic [NUM_W-1:0]    num_u, num_v;
    logic [NRM_W-1:0]    den_u, den_v;
    logic [TEX_W-1:0]    tx, ty;

    t_face               out_face;
    logic [TEX_W-1:0]    out_tx, out_ty;
    logic [IDX_W-1:0]    out_idx;

    // stall control: every stage moves together
    assign en            = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // configuration register and derived size terms
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= SIZE_W'(128);
        end else if (i_cfg_valid) begin
            r_face_size <= i_cfg_data;
        end
    end

    // zero acts as one, anything above the maximum saturates
    always_comb begin
        if (r_face_size == '0) begin
            size = SIZE_W'(1);
        end else if (r_face_size > SIZE_W'(MAX_FACE_SIZE)) begin
            size = SIZE_W'(MAX_FACE_SIZE);
        end else begin
            size = r_face_size;
        end
        span = TEX_W'(size - SIZE_W'(1));
    end

    always_ff @(posedge i_clk) begin
        r_size_sq <= SQ_W'(size) * SQ_W'(size);
    end

    // stage 1: major axis and face coordinates
    cdtl_face_sel u_face_sel (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dir_x (s_axis_tdata[15:0]),
        .i_dir_y (s_axis_tdata[31:16]),
        .i_dir_z (s_axis_tdata[47:32]),
        .o_sel   (sel)
    );

    // stages 2 and 3: shift, clamp and scale each coordinate
    cdtl_scale u_scale_u (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (sel.u),
        .i_mag   (sel.mag),
        .i_span  (span),
        .o_num   (num_u),
        .o_den   (den_u)
    );

    cdtl_scale u_scale_v (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (sel.v),
        .i_mag   (sel.mag),
        .i_span  (span),
        .o_num   (num_v),
        .o_den   (den_v)
    );

    // face offset into the face-major array, then carried alongside the divide
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_face_s2 <= sel.face;
            r_off_s2  <= IDX_W'(IDX_W'(sel.face) * IDX_W'(r_size_sq));
            r_face_s3 <= r_face_s2;
            r_off_s3  <= r_off_s2;
            r_face_d[0] <= r_face_s3;
            r_off_d[0]  <= r_off_s3;
            for (int k = 1; k < TEX_W; k++) begin
                r_face_d[k] <= r_face_d[k-1];
                r_off_d[k]  <= r_off_d[k-1];
            end
        end
    end

    // stages 4 to 14: texel = floor(n * span / 2m)
    cdtl_div u_div_u (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_u),
        .i_den  (den_u),
        .o_quot (tx)
    );

    cdtl_div u_div_v (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_v),
        .i_den  (den_v),
        .o_quot (ty)
    );

    // stages 15 and 16: linear index, last stage is the output register
    cdtl_addr u_addr (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_face     (r_face_d[TEX_W-1]),
        .i_face_off (r_off_d[TEX_W-1]),
        .i_tx       (tx),
        .i_ty       (ty),
        .i_size     (size),
        .o_face     (out_face),
        .o_tx       (out_tx),
        .o_ty       (out_ty),
        .o_idx      (out_idx)
    );

    assign m_axis_tdata = {
        (OUT_TDATA_W - FACE_W - 2 * TEX_W - IDX_W)'(0),
        out_idx,
        out_ty,
        out_tx,
        out_face
    };

endmodule

`default_nettype wire

FILE: dv/tb_cubemap_direction_texel_lookup_top.sv
// testbench for the cubemap direction to face and nearest texel lookup
`timescale 1ns / 1ps

module tb_cubemap_direction_texel_lookup_top;
    import cdtl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;   // far above the slowest correct run
    localparam int DRAIN_CYCLES = 40;      // pipeline is 16 deep

    // one looked-up texel as the block reports it
    typedef struct {
        t_face            face;
        logic [TEX_W-1:0] texel_x;
        logic [TEX_W-1:0] texel_y;
        logic [IDX_W-1:0] texel_index;
    } t_texel_result;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // face [2:0], texel_x [13:3], texel_y [24:14], texel_index [49:25], zero [55:50]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [SIZE_W-1:0]      i_cfg_data = '0;

    t_texel_result          pending_texels[$];
    logic [SIZE_W-1:0]      face_size_shadow = 12'd128;
    bit                     no_gaps = 1'b0;
    int                     mismatch_count = 0;
    int                     cycle_count = 0;

    cubemap_direction_texel_lookup_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // shifted coordinate over twice the major magnitude, scaled and clamped
    function automatic int coord_to_texel(int c, int m, int span);
        longint n;
        longint top;
        longint t;
        n = longint'(c) + longint'(m);
        top = 2 * longint'(m);
        if (n < 0) n = 0;
        if (n > top) n = top;
        t = (n * span) / top;
        if (t > span) t = span;
        return int'(t);
    endfunction

    function automatic t_texel_result predict_texel(logic signed [DIR_W-1:0] dx,
                                                    logic signed [DIR_W-1:0] dy,
                                                    logic signed [DIR_W-1:0] dz,
                                                    logic [SIZE_W-1:0] size_reg);
        int x, y, z, ax, ay, az;
        int u, v, m, sz, tx, ty;
        longint idx;
        t_texel_result r;
        x = dx;
        y = dy;
        z = dz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        // ties go to z first, then x
        if (az >= ax && az >= ay) begin
            r.face = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
            u = (z > 0) ? x : -x;
            v = y;
            m = az;
        end else if (ax >= ay) begin
            r.face = (x > 0) ? FACE_POS_X : FACE_NEG_X;
            u = (x > 0) ? -z : z;
            v = y;
            m = ax;
        end else begin
            r.face = (y > 0) ? FACE_POS_Y : FACE_NEG_Y;
            u = x;
            v = (y > 0) ? -z : z;
            m = ay;
        end
        if (m < FLOOR_MAG) m = FLOOR_MAG;
        sz = size_reg;
        if (sz < 1) sz = 1;
        if (sz > MAX_FACE_SIZE) sz = MAX_FACE_SIZE;
        tx = coord_to_texel(u, m, sz - 1);
        ty = coord_to_texel(v, m, sz - 1);
        idx = longint'(r.face) * sz * sz + longint'(ty) * sz + tx;
        r.texel_x = tx[TEX_W-1:0];
        r.texel_y = ty[TEX_W-1:0];
        r.texel_index = idx[IDX_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // outputs and inputs are stable at the falling edge, so a handshake seen
    // here is the one that completes at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_texels.size() == 0) begin
                report_mismatch("unexpected item, tdata", m_axis_tdata, 0);
            end else begin
                t_texel_result want;
                want = pending_texels.pop_front();
                if (m_axis_tdata[2:0] !== want.face)
                    report_mismatch("face", m_axis_tdata[2:0], want.face);
                if (m_axis_tdata[13:3] !== want.texel_x)
                    report_mismatch("texel_x", m_axis_tdata[13:3], want.texel_x);
                if (m_axis_tdata[24:14] !== want.texel_y)
                    report_mismatch("texel_y", m_axis_tdata[24:14], want.texel_y);
                if (m_axis_tdata[49:25] !== want.texel_index)
                    report_mismatch("texel_index", m_axis_tdata[49:25], want.texel_index);
                if (m_axis_tdata[55:50] !== 6'd0)
                    report_mismatch("pad bits", m_axis_tdata[55:50], 0);
            end
        end
    end

    // receiver with a random stall before every item
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge i_clk); while (!m_axis_tvalid);
            @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers, all called right after a rising edge
    // ---------------------------------------------------------------

    task automatic send_dir(logic signed [DIR_W-1:0] x, logic signed [DIR_W-1:0] y,
                            logic signed [DIR_W-1:0] z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        pending_texels.insert(pending_texels.size(),
                              predict_texel(x, y, z, face_size_shadow));
    endtask

    // sender goes quiet until every result is back
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_texels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_face_size(logic [SIZE_W-1:0] value);
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        face_size_shadow = value;
    endtask

    // mix of full range, near zero and extreme components
    function automatic logic [DIR_W-1:0] pick_component();
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            k = $urandom;
        end else if (sel < 80) begin
            k = $urandom_range(0, 8);
            k = k - 4;
        end else begin
            case ($urandom_range(0, 3))
                0: k = -32768;
                1: k = -32767;
                2: k = 32767;
                default: k = 0;
            endcase
        end
        return k[DIR_W-1:0];
    endfunction

    task automatic send_random_dir();
        logic [DIR_W-1:0] c[3];
        int a, b;
        foreach (c[i]) c[i] = pick_component();
        // force a magnitude tie between two axes now and then
        if ($urandom_range(0, 4) == 0) begin
            a = $urandom_range(0, 2);
            b = (a + $urandom_range(1, 2)) % 3;
            c[b] = $urandom_range(0, 1) ? c[a] : -c[a];
        end
        send_dir(c[0], c[1], c[2]);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // extremes, every face and tie cases with the reset face size
    task automatic test_directed_reset_size();
        send_dir(0, 0, 0);                  // zero vector lands on -z center
        send_dir(-32768, 0, 0);
        send_dir(0, -32768, 0);
        send_dir(0, 0, -32768);
        send_dir(32767, 0, 0);
        send_dir(0, 32767, 0);
        send_dir(0, 0, 32767);
        send_dir(100, 100, 100);            // three way tie, z wins
        send_dir(100, -100, 0);             // x over y
        send_dir(-100, -100, 50);
        send_dir(-32768, 32767, -32768);    // most negative on both x and z
        send_dir(-32768, -32768, -32768);
        send_dir(16384, 8000, -12000);      // +x with both coordinates off center
        send_dir(-16384, -8000, 12000);     // -x
        send_dir(3000, 16384, -9000);       // +y
        send_dir(-3000, -16384, 9000);      // -y
        send_dir(-7000, 5000, 16384);       // +z
        send_dir(7000, -5000, -16384);      // -z
        send_dir(1, 0, 0);                  // magnitude below the floor
        send_dir(1, -1, 1);
        send_dir(0, 0, -1);
        send_dir(32767, -32768, 12345);     // y wins by one lsb
        send_dir(16384, -16384, 16383);
        send_dir(-1, -1, -1);
        drain_pipe();
    endtask

    // face size register through its extremes, each with random items
    task automatic test_face_size_sweep();
        logic [SIZE_W-1:0] sizes[$];
        sizes = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd2, 12'd3, 12'd2047, 12'd2049,
                  12'd127, 12'd1024};
        repeat (2) sizes.insert(sizes.size(), SIZE_W'($urandom_range(0, 4095)));
        foreach (sizes[i]) begin
            write_face_size(sizes[i]);
            repeat (35) send_random_dir();
        end
        drain_pipe();
    endtask

    // full rate on both sides to keep every stage busy
    task automatic test_back_to_back();
        write_face_size(SIZE_W'($urandom_range(1, 2048)));
        no_gaps = 1'b1;
        repeat (120) send_random_dir();
        no_gaps = 1'b0;
        drain_pipe();
    endtask

    // random gaps and stalls with occasional size changes between bursts
    task automatic test_random_mix();
        repeat (4) begin
            write_face_size(SIZE_W'($urandom));
            repeat (30) send_random_dir();
        end
        write_face_size(12'd128);
        repeat (10) send_random_dir();
        drain_pipe();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_reset_size();
        test_face_size_sweep();
        test_back_to_back();
        test_random_mix();
        // results are all back, give the pipe time to show anything extra
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_texels.size() != 0)
            report_mismatch("items never returned", pending_texels.size(), 0);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cdtl_pkg.sv
rtl/cdtl_face_sel.sv
rtl/cdtl_scale.sv
rtl/cdtl_div.sv
rtl/cdtl_addr.sv
rtl/cubemap_direction_texel_lookup_top.sv
dv/tb_cubemap_direction_texel_lookup_top.sv
